// File: hw/rtl/bdx_pkg.sv
package bdx_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int HEIGHT_LIMIT   = 2048;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_PORT_W = 8;
  localparam int SUM_W      = PIX_PORT_W + 1;
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0] line_sum;
    logic [SUM_W-1:0] pair_sum;
    logic             row_end;
    logic             frame_end;
  } job_t;

  // zero acts as one, anything above the limit saturates
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) begin
      return CFG_W'(1);
    end else if (int'(v) > limit) begin
      return CFG_W'(limit);
    end else begin
      return v;
    end
  endfunction

endpackage

// File: hw/rtl/box_downscale_2x2_unit.sv
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------
// pixel in  | push / full             | pixel_value
// result    | pop / empty             | avg_value, row_end, frame_end
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel per clock while full is low; after its last pixel a result passes the
// front job register, the job queue and the output register. The rate is set by the
// single-port line store: one write or one read per pair of pixels. Reset clears
// counters and queues and loads width 640, height 480; line store contents are left
// as they are and need no clearing pass. full rises when the jobs in the 4-entry
// job queue plus the job in flight reach 4. cfg_ready is always high.
module box_downscale_2x2_unit import bdx_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [PIX_PORT_W-1:0] pixel_value,
  output logic                  empty,
  input  logic                  pop,
  output logic [PIX_PORT_W-1:0] avg_value,
  output logic                  row_end,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic               accept;
  logic               job_valid;
  job_t               job;
  job_t               q_head;
  logic               q_valid;
  logic               q_take;
  logic [Q_CNT_W-1:0] q_count;
  logic [Q_CNT_W:0]   pending;

  assign cfg_ready = 1'b1;
  assign pending   = {1'b0, q_count} + (Q_CNT_W + 1)'(job_valid);
  assign full      = pending >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept    = push && !full;

  bdx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_value (pixel_value),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .job_valid   (job_valid),
    .job         (job)
  );

  bdx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (job_valid),
    .push_data (job),
    .pop_en    (q_take),
    .head      (q_head),
    .not_empty (q_valid),
    .count     (q_count)
  );

  bdx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .q_take    (q_take),
    .pop       (pop),
    .empty     (empty),
    .avg_value (avg_value),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule

// File: hw/rtl/bdx_front.sv
module bdx_front import bdx_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [PIX_PORT_W-1:0] pixel_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  job_valid,
  output job_t                  job
);

  localparam int PIX_W      = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;
  localparam int LINE_W     = PIX_W + 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CMP_W      = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam logic [PIX_PORT_W-1:0] PIX_MASK = PIX_PORT_W'((1 << PIX_W) - 1);

  logic [CFG_W-1:0]      frame_w;
  logic [CFG_W-1:0]      frame_h;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [PIX_PORT_W-1:0] held;
  logic [LINE_W-1:0]     line_mem [LINE_DEPTH];
  logic [LINE_W-1:0]     rd_data;
  logic [SUM_W-1:0]      pair_r;
  logic                  row_end_r;
  logic                  frame_end_r;

  logic [PIX_PORT_W-1:0] pix;
  logic [SUM_W-1:0]      pair;
  logic [ADDR_W-1:0]     slot;
  logic [CFG_W-1:0]      last_col;
  logic [CFG_W-1:0]      last_row;
  logic [CMP_W-1:0]      col_ext;
  logic [CMP_W-1:0]      row_ext;
  logic [CMP_W-1:0]      w_ext;
  logic [CMP_W-1:0]      h_ext;
  logic                  col_wrap;
  logic                  row_wrap;
  logic                  wr_line;
  logic                  rd_line;
  logic                  is_row_end;
  logic                  is_frame_end;

  assign pix      = pixel_value & PIX_MASK;
  assign pair     = SUM_W'(held) + SUM_W'(pix);
  assign slot     = ADDR_W'(col >> 1);
  assign last_col = {frame_w[CFG_W-1:1], 1'b0} - CFG_W'(1);
  assign last_row = {frame_h[CFG_W-1:1], 1'b0} - CFG_W'(1);
  assign col_ext  = CMP_W'(col);
  assign row_ext  = CMP_W'(row);
  assign w_ext    = CMP_W'(frame_w);
  assign h_ext    = CMP_W'(frame_h);
  assign col_wrap = (col_ext + CMP_W'(1)) >= w_ext;
  assign row_wrap = (row_ext + CMP_W'(1)) >= h_ext;

  assign wr_line = accept && col[0] && !row[0];
  assign rd_line = accept && col[0] && row[0] && (col_ext < w_ext) && (row_ext < h_ext);

  assign is_row_end   = col_ext == CMP_W'(last_col);
  assign is_frame_end = is_row_end && (row_ext == CMP_W'(last_row));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w   <= clamp_dim(WIDTH_RESET, MAX_WIDTH);
      frame_h   <= clamp_dim(HEIGHT_RESET, HEIGHT_LIMIT);
      col       <= '0;
      row       <= '0;
      held      <= '0;
      job_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w <= clamp_dim(cfg_data, MAX_WIDTH);
          REG_FRAME_HEIGHT: frame_h <= clamp_dim(cfg_data, HEIGHT_LIMIT);
          default: ;
        endcase
      end
      if (accept) begin
        if (!col[0]) begin
          held <= pix;
        end
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
      job_valid <= rd_line;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_line) begin
      line_mem[slot] <= pair[LINE_W-1:0];
    end
    if (rd_line) begin
      rd_data     <= line_mem[slot];
      pair_r      <= pair;
      row_end_r   <= is_row_end;
      frame_end_r <= is_frame_end;
    end
  end

  assign job.line_sum  = SUM_W'(rd_data);
  assign job.pair_sum  = pair_r;
  assign job.row_end   = row_end_r;
  assign job.frame_end = frame_end_r;

endmodule

// File: hw/rtl/bdx_queue.sv
module bdx_queue import bdx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_en,
  input  job_t               push_data,
  input  logic               pop_en,
  output job_t               head,
  output logic               not_empty,
  output logic [Q_CNT_W-1:0] count
);

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop_en) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({push_en, pop_en})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/bdx_back.sv
module bdx_back import bdx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  job_t                  q_job,
  output logic                  q_take,
  input  logic                  pop,
  output logic                  empty,
  output logic [PIX_PORT_W-1:0] avg_value,
  output logic                  row_end,
  output logic                  frame_end
);

  logic             out_valid;
  logic [SUM_W:0]   block_sum;

  assign block_sum = (SUM_W + 1)'(q_job.line_sum) + (SUM_W + 1)'(q_job.pair_sum);
  assign q_take    = q_valid && (!out_valid || pop);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      avg_value <= block_sum[SUM_W:2];
      row_end   <= q_job.row_end;
      frame_end <= q_job.frame_end;
    end
  end

endmodule
